// File: sv/fcfd_pkg.sv
// ---------------------------------------------------------------------------
// fcfd_pkg: shared definitions of the filled-circle framebuffer
// Default store size, command and response codes, register indexes,
// the sequencer state type and the white reset colour.
// ---------------------------------------------------------------------------
`default_nettype none

package fcfd_pkg;

  // Default framebuffer dimensions in pixels.
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Coordinate arithmetic width. It holds every bound and every offset
  // that a draw can produce, signed.
  localparam int CW = 12;

  // One pixel is red, green and blue, eight bits each.
  localparam int PIX_W = 24;
  localparam logic [PIX_W-1:0] WHITE = 24'hFFFFFF;

  // Size register width and reset value.
  localparam int SIZE_W = 7;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Command codes.
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Response codes.
  localparam logic RESP_DRAW = 1'b0;
  localparam logic RESP_READ = 1'b1;

  // Register indexes.
  localparam logic REG_IMG_WIDTH  = 1'b0;
  localparam logic REG_IMG_HEIGHT = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

// File: sv/filled_circle_framebuffer_draw.sv
// ---------------------------------------------------------------------------
// filled_circle_framebuffer_draw: RGB framebuffer with filled-circle draw
// Holds a MAX_WIDTH by MAX_HEIGHT pixel store, draws clipped filled circles
// into it and returns single pixels on request.
// ---------------------------------------------------------------------------
// After reset the block sweeps the whole store to white, one pixel a cycle,
// with busy high until the pass ends and the first command can be taken;
// register writes are accepted during that pass. A command is taken when
// start is high and busy is low. A read keeps busy high while the store is
// read, and its result appears on the cycle after. A draw visits every pixel
// of the circle's bounding box clipped to the image size, one pixel a cycle
// through the single store port, keeping busy high while it runs;
// its completion result follows on the next cycle. Each result is shown for
// exactly one cycle with out_valid high and cannot be held off by the
// receiver; a new command may be started in the same cycle in which a result
// is shown.
// ---------------------------------------------------------------------------
`default_nettype none

module filled_circle_framebuffer_draw
  import fcfd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  // Command channel.
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_cmd,
  input  wire logic signed [8:0] in_center_x,
  input  wire logic signed [8:0] in_center_y,
  input  wire logic        [7:0] in_radius,
  input  wire logic        [7:0] in_red,
  input  wire logic        [7:0] in_green,
  input  wire logic        [7:0] in_blue,
  input  wire logic        [5:0] in_pixel_x,
  input  wire logic        [5:0] in_pixel_y,

  // Result channel.
  output logic                   out_valid,
  output logic                   out_resp_kind,
  output logic             [7:0] out_red,
  output logic             [7:0] out_green,
  output logic             [7:0] out_blue,

  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic        [2:0] paddr,
  input  wire logic       [31:0] pwdata,
  output logic            [31:0] prdata,
  output logic                   pready
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_WIDTH);
  localparam logic [CW-1:0]     MAX_W_C   = CW'(MAX_WIDTH);
  localparam logic [CW-1:0]     MAX_H_C   = CW'(MAX_HEIGHT);

  // Configuration registers.
  logic [SIZE_W-1:0] img_width_r;
  logic [SIZE_W-1:0] img_height_r;
  logic              cfg_wr;

  // Sequencer.
  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;

  // Latched command.
  logic signed [8:0] cx_r, cy_r;
  logic        [7:0] rad_r;
  logic [PIX_W-1:0]  colour_r;
  logic              oob_r;

  // Clipped box and scan position.
  logic [15:0] r2_r;
  logic [6:0]  left_r, right_r, bottom_r;
  logic [6:0]  x_r, y_r;

  // Distance stage.
  logic              p_valid_r;
  logic [17:0]       sq_x_r, sq_y_r;
  logic [ADDR_W-1:0] p_addr_r;

  // Store port.
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;

  // Result registers.
  logic       out_valid_r, out_resp_kind_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;

  // ---- Configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= SIZE_RESET;
      img_height_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMG_WIDTH:  img_width_r  <= pwdata[SIZE_W-1:0];
        REG_IMG_HEIGHT: img_height_r <= pwdata[SIZE_W-1:0];
        default:        img_width_r  <= img_width_r;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_IMG_WIDTH:  prdata = {25'd0, img_width_r};
      REG_IMG_HEIGHT: prdata = {25'd0, img_height_r};
      default:        prdata = '0;
    endcase
  end

  // ---- Bounding box setup ----
  logic        [CW-1:0] w_eff, h_eff;
  logic signed [CW-1:0] cx_e, cy_e, r_e;
  logic signed [CW-1:0] top_raw, bot_raw, left_raw, right_raw;
  logic signed [CW-1:0] top_c, bot_c, left_c, right_c;
  logic                 box_nonempty;

  // The image size in use never exceeds the store.
  assign w_eff = (CW'(img_width_r) < MAX_W_C) ? CW'(img_width_r) : MAX_W_C;
  assign h_eff = (CW'(img_height_r) < MAX_H_C) ? CW'(img_height_r) : MAX_H_C;

  assign cx_e = {{(CW-9){cx_r[8]}}, cx_r};
  assign cy_e = {{(CW-9){cy_r[8]}}, cy_r};
  assign r_e  = {{(CW-8){1'b0}}, rad_r};

  assign top_raw   = cy_e - r_e;
  assign bot_raw   = cy_e + r_e;
  assign left_raw  = cx_e - r_e;
  assign right_raw = cx_e + r_e;

  assign top_c   = (top_raw < 0) ? '0 : top_raw;
  assign left_c  = (left_raw < 0) ? '0 : left_raw;
  assign bot_c   = (bot_raw > $signed(h_eff)) ? $signed(h_eff) : bot_raw;
  assign right_c = (right_raw > $signed(w_eff)) ? $signed(w_eff) : right_raw;

  assign box_nonempty = (left_c < right_c) && (top_c < bot_c);

  // ---- Scan stepping ----
  logic row_end, box_end;

  assign row_end = (x_r == right_r - 7'd1);
  assign box_end = row_end && (y_r == bottom_r - 7'd1);

  // ---- Distance of the current pixel from the centre ----
  logic signed [CW-1:0]   dx, dy;
  logic signed [2*CW-1:0] dx_sq, dy_sq;
  logic [ADDR_W-1:0]      scan_addr;

  assign dx    = $signed({{(CW-7){1'b0}}, x_r}) - cx_e;
  assign dy    = $signed({{(CW-7){1'b0}}, y_r}) - cy_e;
  assign dx_sq = (2*CW)'(dx) * (2*CW)'(dx);
  assign dy_sq = (2*CW)'(dy) * (2*CW)'(dy);
  assign scan_addr = ADDR_W'(y_r) * ROW_STEP + ADDR_W'(x_r);

  // Inside test on the registered squares.
  logic [18:0] dist2;
  logic        pixel_hit;

  assign dist2     = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign pixel_hit = dist2 < {3'd0, r2_r};

  // ---- Read address ----
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_oob;

  assign rd_addr = ADDR_W'(in_pixel_y) * ROW_STEP + ADDR_W'(in_pixel_x);
  assign rd_oob  = (CW'(in_pixel_x) >= MAX_W_C) || (CW'(in_pixel_y) >= MAX_H_C);

  // ---- Sequencer next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = (in_cmd == CMD_READ) ? ST_READ : ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = box_nonempty ? ST_SCAN : ST_DRAIN;
      end
      ST_SCAN: begin
        if (box_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // ---- Sequencer outputs and store port control ----
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = p_addr_r;
    ram_wdata = colour_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_r;
        ram_wdata = WHITE;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        ram_re   = start && (in_cmd == CMD_READ);
        ram_addr = rd_addr;
      end
      ST_SCAN, ST_DRAIN: begin
        ram_we = p_valid_r && pixel_hit;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---- Control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_valid_r   <= (state_r == ST_SCAN);
      out_valid_r <= (state_r == ST_DRAIN) || (state_r == ST_READ);
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // ---- Datapath registers ----
  always_ff @(posedge clk) begin
    // Latch the command at acceptance.
    if (state_r == ST_IDLE && start) begin
      cx_r     <= in_center_x;
      cy_r     <= in_center_y;
      rad_r    <= in_radius;
      colour_r <= {in_red, in_green, in_blue};
      oob_r    <= rd_oob;
    end

    // Clip the box and square the radius.
    if (state_r == ST_SETUP) begin
      r2_r     <= 16'(rad_r) * 16'(rad_r);
      left_r   <= left_c[6:0];
      right_r  <= right_c[6:0];
      bottom_r <= bot_c[6:0];
      x_r      <= left_c[6:0];
      y_r      <= top_c[6:0];
    end

    // Walk the box row by row and register the squared offsets.
    if (state_r == ST_SCAN) begin
      sq_x_r   <= dx_sq[17:0];
      sq_y_r   <= dy_sq[17:0];
      p_addr_r <= scan_addr;
      if (row_end) begin
        x_r <= left_r;
        y_r <= y_r + 7'd1;
      end else begin
        x_r <= x_r + 7'd1;
      end
    end

    // Result payload.
    if (state_r == ST_DRAIN) begin
      out_resp_kind_r <= RESP_DRAW;
      out_red_r       <= '0;
      out_green_r     <= '0;
      out_blue_r      <= '0;
    end else if (state_r == ST_READ) begin
      out_resp_kind_r <= RESP_READ;
      out_red_r       <= oob_r ? 8'd0 : ram_rdata[23:16];
      out_green_r     <= oob_r ? 8'd0 : ram_rdata[15:8];
      out_blue_r      <= oob_r ? 8'd0 : ram_rdata[7:0];
    end
  end

  // ---- Pixel store ----
  fcfd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_resp_kind = out_resp_kind_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;

  // ---- Assertions ----

  // A result is shown only once the sequencer is back to idle.
  a_result_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result shown while the sequencer is not idle");

  // The distance stage holds a pixel only during or right after the scan.
  a_stage_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("distance stage valid outside the scan");

  // The scan position stays inside the clipped box.
  a_scan_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (x_r < right_r && y_r < bottom_r && x_r >= left_r))
    else $error("scan position left the clipped box");

  // A store read is followed by a read result.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (out_valid_r && out_resp_kind_r == RESP_READ))
    else $error("read transaction did not produce a read result");

  // The store is never written and read in the same cycle.
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

endmodule

`default_nettype wire

// File: sv/fcfd_ram.sv
// ---------------------------------------------------------------------------
// fcfd_ram: generic single-port synchronous RAM with registered read data
// The user makes one access per cycle, write or read; not enforced here.
// ---------------------------------------------------------------------------
`default_nettype none

module fcfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire
